### design/sunscreen_position_controller_defines.svh
// assertion macros for the sun screen position controller checker
`ifndef SUNSCREEN_POSITION_CONTROLLER_DEFINES_SVH
`define SUNSCREEN_POSITION_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define SPC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spc checker: implication failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define SPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spc checker: next-cycle implication failed");

`endif

### design/spc_pkg.sv
// types, constants and distance conversion for the sun screen position controller
package spc_pkg;

  localparam int unsigned SAMPLE_BITS  = 10;
  localparam int unsigned TICK_BITS    = 10;
  localparam int unsigned CHAR_BITS    = 8;
  localparam int unsigned DIST_BITS    = 10;
  localparam int unsigned CM_BITS      = 8;
  localparam int unsigned PADDR_BITS   = 4;
  localparam int unsigned PDATA_BITS   = 32;

  localparam int unsigned ECHO_TIMEOUT = 500;
  localparam int unsigned TICK_US      = 60;
  localparam int unsigned US_PER_CM    = 58;

  // ticks * 60 / 58 == ticks + ticks / 29
  localparam int unsigned DIV_BY       = US_PER_CM / (TICK_US - US_PER_CM);
  localparam int unsigned DIV_SHIFT    = 14;
  localparam int unsigned DIV_MUL      = ((2 ** DIV_SHIFT) + DIV_BY - 1) / DIV_BY;
  localparam int unsigned PROD_BITS    = TICK_BITS + DIV_SHIFT - 4;
  localparam int unsigned QUOT_BITS    = PROD_BITS - DIV_SHIFT;

  localparam logic [TICK_BITS-1:0] ECHO_CAP = TICK_BITS'(ECHO_TIMEOUT + 1);
  localparam logic [DIST_BITS:0]   DIST_MAX = (DIST_BITS + 1)'((2 ** DIST_BITS) - 1);

  localparam logic [CHAR_BITS-1:0] CHAR_LOWER = 8'h31;
  localparam logic [CHAR_BITS-1:0] CHAR_RAISE = 8'h32;

  localparam logic [SAMPLE_BITS-1:0] SENSOR_LOW_RST  = 10'h08b;
  localparam logic [SAMPLE_BITS-1:0] SENSOR_HIGH_RST = 10'h097;
  localparam logic [CM_BITS-1:0]     SCREEN_LOW_RST  = 8'h05;
  localparam logic [CM_BITS-1:0]     SCREEN_HIGH_RST = 8'h96;

  typedef enum logic [1:0] {
    MODE_SENSOR  = 2'd0,
    MODE_ECHO    = 2'd1,
    MODE_COMMAND = 2'd2,
    MODE_BLINK   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_SENSOR_LOW  = 2'd0,
    REG_SENSOR_HIGH = 2'd1,
    REG_SCREEN_LOW  = 2'd2,
    REG_SCREEN_HIGH = 2'd3
  } reg_idx_e;

  function automatic logic [DIST_BITS-1:0] ticks_to_cm(input logic [TICK_BITS-1:0] ticks);
    logic [TICK_BITS-1:0] sat;
    logic [PROD_BITS-1:0] prod;
    logic [QUOT_BITS-1:0] quot;
    logic [DIST_BITS:0]   cm;
    sat  = (ticks > ECHO_CAP) ? ECHO_CAP : ticks;
    prod = PROD_BITS'(sat) * PROD_BITS'(DIV_MUL);
    quot = prod[PROD_BITS-1:DIV_SHIFT];
    cm   = (DIST_BITS + 1)'(sat) + (DIST_BITS + 1)'(quot);
    return (cm > DIST_MAX) ? DIST_MAX[DIST_BITS-1:0] : cm[DIST_BITS-1:0];
  endfunction

endpackage

### design/sunscreen_position_controller.sv
// sun screen position controller top level: input register, event logic, state/result register
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------------------
//   in       | in_valid_i / in_ready_o    | mode_i, sensor_sample_i, echo_ticks_i,
//            |                            | command_char_i
//   out      | out_valid_o / out_ready_i  | screen_down_o, moving_o, blink_led_o,
//            |                            | distance_cm_o
//   config   | psel/penable/pwrite/pready | paddr, pwdata, prdata (four registers)
//
// one item per cycle sustained while the output is not stalled; an accepted item goes
// through the input register, then the event logic and the state register, to the output
// the state flags double as the result register, so the output shows the state after the item
// a stalled output holds the input register; a third item waits for in_ready_o
// reset clears the flags to screen up, moving, led off, distance zero, and loads default limits
module sunscreen_position_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       mode_i,
  input  logic [spc_pkg::SAMPLE_BITS-1:0]  sensor_sample_i,
  input  logic [spc_pkg::TICK_BITS-1:0]    echo_ticks_i,
  input  logic [spc_pkg::CHAR_BITS-1:0]    command_char_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             screen_down_o,
  output logic                             moving_o,
  output logic                             blink_led_o,
  output logic [spc_pkg::DIST_BITS-1:0]    distance_cm_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [spc_pkg::PADDR_BITS-1:0]   paddr,
  input  logic [spc_pkg::PDATA_BITS-1:0]   pwdata,
  output logic [spc_pkg::PDATA_BITS-1:0]   prdata,
  output logic                             pready
);
  import spc_pkg::*;

  logic [SAMPLE_BITS-1:0] sensor_low_q, sensor_high_q;
  logic [CM_BITS-1:0]     screen_low_q, screen_high_q;
  reg_idx_e               reg_idx;
  logic                   cfg_write;

  logic                   s1_valid_q;
  mode_e                  s1_mode_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic [TICK_BITS-1:0]   s1_ticks_q;
  logic [CHAR_BITS-1:0]   s1_char_q;

  logic                   out_valid_q;
  logic                   advance;
  logic                   in_accept;

  logic                   down_q, down_d;
  logic                   moving_q, moving_d;
  logic                   phase_q, phase_d;
  logic                   led_q, led_d;
  logic [DIST_BITS-1:0]   dist_q, dist_d;
  logic [DIST_BITS-1:0]   echo_cm;

  // config port
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[PADDR_BITS-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_low_q  <= SENSOR_LOW_RST;
      sensor_high_q <= SENSOR_HIGH_RST;
      screen_low_q  <= SCREEN_LOW_RST;
      screen_high_q <= SCREEN_HIGH_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_SENSOR_LOW:  sensor_low_q  <= pwdata[SAMPLE_BITS-1:0];
        REG_SENSOR_HIGH: sensor_high_q <= pwdata[SAMPLE_BITS-1:0];
        REG_SCREEN_LOW:  screen_low_q  <= pwdata[CM_BITS-1:0];
        REG_SCREEN_HIGH: screen_high_q <= pwdata[CM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SENSOR_LOW:  prdata = PDATA_BITS'(sensor_low_q);
      REG_SENSOR_HIGH: prdata = PDATA_BITS'(sensor_high_q);
      REG_SCREEN_LOW:  prdata = PDATA_BITS'(screen_low_q);
      REG_SCREEN_HIGH: prdata = PDATA_BITS'(screen_high_q);
      default:         prdata = '0;
    endcase
  end

  // handshake
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mode_q   <= mode_e'(mode_i);
      s1_sample_q <= sensor_sample_i;
      s1_ticks_q  <= echo_ticks_i;
      s1_char_q   <= command_char_i;
    end
  end

  // event logic
  assign echo_cm = ticks_to_cm(s1_ticks_q);

  always_comb begin
    down_d   = down_q;
    moving_d = moving_q;
    phase_d  = phase_q;
    led_d    = led_q;
    dist_d   = dist_q;
    case (s1_mode_q)
      MODE_SENSOR: begin
        if (s1_sample_q > sensor_high_q && !down_d) begin
          down_d   = 1'b1;
          moving_d = 1'b1;
        end
        if (s1_sample_q < sensor_low_q && down_d) begin
          down_d   = 1'b0;
          moving_d = 1'b1;
        end
      end
      MODE_ECHO: begin
        dist_d = echo_cm;
        if (moving_q) begin
          if (echo_cm <= DIST_BITS'(screen_low_q) && down_q) begin
            moving_d = 1'b0;
          end
          if (echo_cm >= DIST_BITS'(screen_high_q) && !down_q) begin
            moving_d = 1'b0;
          end
        end
      end
      MODE_COMMAND: begin
        if (s1_char_q == CHAR_LOWER && !down_q) begin
          down_d   = 1'b1;
          moving_d = 1'b1;
        end else if (s1_char_q == CHAR_RAISE && down_q) begin
          down_d   = 1'b0;
          moving_d = 1'b1;
        end
      end
      MODE_BLINK: begin
        led_d   = phase_q && moving_q;
        phase_d = !phase_q;
      end
      default: ;
    endcase
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q   <= 1'b0;
      moving_q <= 1'b1;
      phase_q  <= 1'b0;
      led_q    <= 1'b0;
      dist_q   <= '0;
    end else if (advance) begin
      down_q   <= down_d;
      moving_q <= moving_d;
      phase_q  <= phase_d;
      led_q    <= led_d;
      dist_q   <= dist_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign screen_down_o = down_q;
  assign moving_o      = moving_q;
  assign blink_led_o   = led_q;
  assign distance_cm_o = dist_q;

endmodule

### design/spc_checker.sv
// port-level checker for the sun screen position controller, bound to the top level
`include "sunscreen_position_controller_defines.svh"

module spc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic                             screen_down_o,
  input logic                             moving_o,
  input logic                             blink_led_o,
  input logic [spc_pkg::DIST_BITS-1:0]    distance_cm_o,
  input logic                             pready
);
  import spc_pkg::*;

  logic [DIST_BITS-1:0] dist_limit;
  assign dist_limit = DIST_BITS'(ECHO_TIMEOUT + 1 + (ECHO_TIMEOUT + 1) / DIV_BY);

  // a stalled item keeps its fields
  `SPC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(screen_down_o) && $stable(moving_o) && $stable(blink_led_o) &&
    $stable(distance_cm_o))

  // with no item waiting at the output the block takes a new item
  `SPC_ASSERT_IMPL(a_ready_when_empty, !out_valid_o, in_ready_o)

  // a converted distance never exceeds the saturated echo range
  `SPC_ASSERT_IMPL(a_dist_range, out_valid_o, distance_cm_o <= dist_limit)

  // the config port never inserts wait states
  `SPC_ASSERT_IMPL(a_pready_high, 1'b1, pready)

endmodule

bind sunscreen_position_controller spc_checker u_spc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .screen_down_o (screen_down_o),
  .moving_o      (moving_o),
  .blink_led_o   (blink_led_o),
  .distance_cm_o (distance_cm_o),
  .pready        (pready)
);

### sim/sunscreen_position_controller_tb.sv
// self-checking testbench for the sun screen position controller with a status predictor
module sunscreen_position_controller_tb;
  import spc_pkg::*;

  typedef struct packed {
    logic                 down;
    logic                 moving;
    logic                 led;
    logic [DIST_BITS-1:0] distance;
  } screen_status_t;

  class screen_tracker;
    logic [SAMPLE_BITS-1:0] low_thr;
    logic [SAMPLE_BITS-1:0] high_thr;
    logic [CM_BITS-1:0]     low_cm;
    logic [CM_BITS-1:0]     high_cm;
    logic                   down;
    logic                   moving;
    logic                   phase;
    logic                   led;
    logic [DIST_BITS-1:0]   distance;
    screen_status_t         expected_status[$];
    int                     errors;

    function new();
      low_thr  = 10'd139;
      high_thr = 10'd151;
      low_cm   = 8'd5;
      high_cm  = 8'd150;
      down     = 1'b0;
      moving   = 1'b1;
      phase    = 1'b0;
      led      = 1'b0;
      distance = '0;
      errors   = 0;
    endfunction

    function void set_limit(reg_idx_e idx, logic [PDATA_BITS-1:0] value);
      case (idx)
        REG_SENSOR_LOW:  low_thr  = value[SAMPLE_BITS-1:0];
        REG_SENSOR_HIGH: high_thr = value[SAMPLE_BITS-1:0];
        REG_SCREEN_LOW:  low_cm   = value[CM_BITS-1:0];
        REG_SCREEN_HIGH: high_cm  = value[CM_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [DIST_BITS-1:0] echo_to_cm(logic [TICK_BITS-1:0] ticks);
      int unsigned t;
      int unsigned cm;
      t  = (ticks > 501) ? 501 : ticks;
      cm = t * 60 / 58;
      if (cm > 1023) cm = 1023;
      return cm[DIST_BITS-1:0];
    endfunction

    function void note_event(logic [1:0] mode, logic [SAMPLE_BITS-1:0] sample,
                             logic [TICK_BITS-1:0] ticks, logic [CHAR_BITS-1:0] ch);
      screen_status_t s;
      case (mode_e'(mode))
        MODE_SENSOR: begin
          if (sample > high_thr && !down) begin
            down   = 1'b1;
            moving = 1'b1;
          end
          if (sample < low_thr && down) begin
            down   = 1'b0;
            moving = 1'b1;
          end
        end
        MODE_ECHO: begin
          distance = echo_to_cm(ticks);
          if (moving) begin
            if (distance <= low_cm && down) moving = 1'b0;
            if (distance >= high_cm && !down) moving = 1'b0;
          end
        end
        MODE_COMMAND: begin
          if (ch == CHAR_LOWER && !down) begin
            down   = 1'b1;
            moving = 1'b1;
          end else if (ch == CHAR_RAISE && down) begin
            down   = 1'b0;
            moving = 1'b1;
          end
        end
        default: begin
          led   = phase && moving;
          phase = !phase;
        end
      endcase
      s.down     = down;
      s.moving   = moving;
      s.led      = led;
      s.distance = distance;
      expected_status.push_back(s);
    endfunction

    function void check_status(screen_status_t act);
      screen_status_t exp_s;
      if (expected_status.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: down %0d moving %0d led %0d dist %0d",
                   act.down, act.moving, act.led, act.distance);
        errors++;
        return;
      end
      exp_s = expected_status.pop_front();
      if (exp_s.down !== act.down || exp_s.moving !== act.moving ||
          exp_s.led !== act.led || exp_s.distance !== act.distance) begin
        if (errors < 10)
          $display("mismatch: expected down %0d moving %0d led %0d dist %0d, got %0d %0d %0d %0d",
                   exp_s.down, exp_s.moving, exp_s.led, exp_s.distance,
                   act.down, act.moving, act.led, act.distance);
        errors++;
      end
    endfunction

    function int pending();
      return expected_status.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            mode_i;
  logic [SAMPLE_BITS-1:0] sensor_sample_i;
  logic [TICK_BITS-1:0]  echo_ticks_i;
  logic [CHAR_BITS-1:0]  command_char_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  screen_down_o;
  logic                  moving_o;
  logic                  blink_led_o;
  logic [DIST_BITS-1:0]  distance_cm_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  screen_tracker tracker;
  int            send_idle_pct;
  int            recv_idle_pct;

  sunscreen_position_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .sensor_sample_i (sensor_sample_i),
    .echo_ticks_i    (echo_ticks_i),
    .command_char_i  (command_char_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .screen_down_o   (screen_down_o),
    .moving_o        (moving_o),
    .blink_led_o     (blink_led_o),
    .distance_cm_o   (distance_cm_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        tracker.check_status({screen_down_o, moving_o, blink_led_o, distance_cm_o});
      if (in_valid_i && in_ready_o)
        tracker.note_event(mode_i, sensor_sample_i, echo_ticks_i, command_char_i);
    end
  end

  task automatic send_item(mode_e m, logic [SAMPLE_BITS-1:0] sample,
                           logic [TICK_BITS-1:0] ticks, logic [CHAR_BITS-1:0] ch);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= m;
    sensor_sample_i <= sample;
    echo_ticks_i    <= ticks;
    command_char_i  <= ch;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_limit(reg_idx_e idx, logic [PDATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_BITS'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_limit(idx, value);
    @(posedge clk_i);
  endtask

  task automatic write_limits(int lo_thr, int hi_thr, int lo_cm, int hi_cm);
    logic [PDATA_BITS-1:0] junk;
    junk = $urandom();
    write_limit(REG_SENSOR_LOW,  {junk[31:10], 10'(lo_thr)});
    junk = $urandom();
    write_limit(REG_SENSOR_HIGH, {junk[31:10], 10'(hi_thr)});
    junk = $urandom();
    write_limit(REG_SCREEN_LOW,  {junk[31:8], 8'(lo_cm)});
    junk = $urandom();
    write_limit(REG_SCREEN_HIGH, {junk[31:8], 8'(hi_cm)});
  endtask

  task automatic random_limits();
    int lo;
    lo = $urandom_range(100, 500);
    write_limits(lo, lo + $urandom_range(0, 400), $urandom_range(0, 30),
                 $urandom_range(100, 255));
  endtask

  task automatic run_random(int n);
    logic [SAMPLE_BITS-1:0] sample;
    logic [TICK_BITS-1:0]   ticks;
    logic [CHAR_BITS-1:0]   ch;
    int                     pick;
    for (int i = 0; i < n; i++) begin
      sample = $urandom();
      ticks  = $urandom();
      ch     = $urandom();
      pick   = $urandom_range(0, 9);
      if (pick < 6) begin
        sample = $urandom_range(0, 1) ? SAMPLE_BITS'(tracker.low_thr + $urandom_range(0, 6) - 3)
                                      : SAMPLE_BITS'(tracker.high_thr + $urandom_range(0, 6) - 3);
        ticks  = $urandom_range(0, 200);
        ch     = $urandom_range(0, 1) ? CHAR_LOWER : CHAR_RAISE;
      end
      send_item(mode_e'($urandom_range(0, 3)), sample, ticks, ch);
    end
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    out_ready_i     = 1'b0;
    mode_i          = MODE_SENSOR;
    sensor_sample_i = '0;
    echo_ticks_i    = '0;
    command_char_i  = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    send_idle_pct   = 33;
    recv_idle_pct   = 83;
    tracker         = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset, field extremes and every mode
    send_item(MODE_BLINK,   10'h3ff, 10'h3ff, 8'hff);
    send_item(MODE_BLINK,   10'h000, 10'h000, 8'h00);
    send_item(MODE_ECHO,    10'h3ff, 10'd0,   8'hff);
    send_item(MODE_ECHO,    10'h000, 10'd1023, 8'h00);
    send_item(MODE_COMMAND, 10'h3ff, 10'h3ff, CHAR_LOWER);
    send_item(MODE_COMMAND, 10'h000, 10'h000, CHAR_LOWER);
    send_item(MODE_BLINK,   10'h155, 10'h2aa, 8'h55);
    send_item(MODE_BLINK,   10'h2aa, 10'h155, 8'haa);
    send_item(MODE_ECHO,    10'h000, 10'd5,   8'h00);
    send_item(MODE_COMMAND, 10'h000, 10'h000, 8'h00);
    send_item(MODE_COMMAND, 10'h000, 10'h000, 8'hff);
    send_item(MODE_COMMAND, 10'h000, 10'h000, 8'h33);
    send_item(MODE_COMMAND, 10'h000, 10'h000, CHAR_RAISE);
    send_item(MODE_COMMAND, 10'h000, 10'h000, CHAR_RAISE);
    send_item(MODE_ECHO,    10'h000, 10'd501, 8'h00);
    send_item(MODE_ECHO,    10'h000, 10'd502, 8'h00);
    send_item(MODE_SENSOR,  10'd151, 10'h000, 8'h00);
    send_item(MODE_SENSOR,  10'd1023, 10'h000, 8'h00);
    send_item(MODE_SENSOR,  10'd139, 10'h000, 8'h00);
    send_item(MODE_SENSOR,  10'd0,   10'h3ff, 8'hff);
    send_item(MODE_ECHO,    10'h3ff, 10'd140, 8'h00);
    send_item(MODE_ECHO,    10'h3ff, 10'd146, 8'h00);
    drain();

    random_limits();
    run_random(120);
    drain();

    // overlapping thresholds: one sample lowers and raises at once
    write_limits(1023, 0, 255, 0);
    send_item(MODE_SENSOR, 10'd500, 10'h000, 8'h00);
    send_item(MODE_SENSOR, 10'd0,   10'h000, 8'h00);
    send_item(MODE_SENSOR, 10'd1023, 10'h000, 8'h00);
    run_random(20);
    drain();

    send_idle_pct = 83;
    recv_idle_pct = 33;
    write_limits(0, 1023, 0, 255);
    run_random(20);
    drain();
    random_limits();
    run_random(110);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_limits();
    run_random(100);
    drain();
    repeat (10) @(posedge clk_i);

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/spc_pkg.sv
design/sunscreen_position_controller.sv
design/spc_checker.sv
sim/sunscreen_position_controller_tb.sv
